[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands, checked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Consequent sequence must follow whenever the antecedent holds.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("assertion failed");

`endif

[design/vrap_pkg.sv]
// ----------------------------------------------------------------------------
// vrap_pkg
// Shared types and constants for the pivot rotation pipeline.
// ----------------------------------------------------------------------------
package vrap_pkg;

  localparam int COORD_WIDTH = 32;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
  } vertex_t;

  typedef struct packed {
    coord_t rotated_x;
    coord_t rotated_y;
    coord_t rotated_z;
  } rotated_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd5;

  localparam int CFG_DATA_W = 32;
  localparam int ANGLE_W    = 16;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

  // pi/2 in Q30 and the Taylor series divisors (2k)(2k+1)
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

endpackage

[design/vrap_rotate.sv]
// ----------------------------------------------------------------------------
// vrap_rotate
// One plane rotation about a pivot: out_a = c*da - s*db, out_b = s*da + c*db.
// ----------------------------------------------------------------------------
module vrap_rotate #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  vrap_pkg::coord_t              in_a,
  input  vrap_pkg::coord_t              in_b,
  input  vrap_pkg::coord_t              in_pass,
  input  vrap_pkg::coord_t              center_a,
  input  vrap_pkg::coord_t              center_b,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_val,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_val,
  output logic                          out_valid,
  output vrap_pkg::coord_t              out_a,
  output vrap_pkg::coord_t              out_b,
  output vrap_pkg::coord_t              out_pass
);
  import vrap_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = DW + TW;
  localparam int SW = PW + 1;
  localparam int RW = SW - TRIG_FRAC_BITS;
  localparam int CW = RW + 1;
  localparam logic signed [SW-1:0] ROUND_HALF = SW'(64'd1 << (TRIG_FRAC_BITS - 1));
  localparam logic signed [CW-1:0] SAT_MAX = CW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [CW-1:0] SAT_MIN = -SAT_MAX - CW'(1);

  // stage 1: offsets from the pivot
  logic                 v1_r;
  logic signed [DW-1:0] da_r, db_r;
  coord_t               pass1_r;
  // stage 2: products
  logic                 v2_r;
  logic signed [PW-1:0] pca_r, psb_r, psa_r, pcb_r;
  coord_t               pass2_r;
  // stage 3: round, re-add pivot, saturate
  logic                 v3_r;
  coord_t               ra_r, rb_r, pass3_r;

  logic signed [SW-1:0] sum_a, sum_b;
  logic signed [RW-1:0] sh_a, sh_b;
  logic signed [CW-1:0] tot_a, tot_b;
  coord_t               ra_nxt, rb_nxt;

  function automatic coord_t sat_coord(input logic signed [CW-1:0] x);
    if (x > SAT_MAX) begin
      return coord_t'(SAT_MAX);
    end else if (x < SAT_MIN) begin
      return coord_t'(SAT_MIN);
    end
    return coord_t'(x);
  endfunction

  always_comb begin
    sum_a  = SW'(pca_r) - SW'(psb_r) + ROUND_HALF;
    sum_b  = SW'(psa_r) + SW'(pcb_r) + ROUND_HALF;
    sh_a   = sum_a[SW-1:TRIG_FRAC_BITS];
    sh_b   = sum_b[SW-1:TRIG_FRAC_BITS];
    tot_a  = CW'(sh_a) + CW'(center_a);
    tot_b  = CW'(sh_b) + CW'(center_b);
    ra_nxt = sat_coord(tot_a);
    rb_nxt = sat_coord(tot_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    da_r    <= DW'(in_a) - DW'(center_a);
    db_r    <= DW'(in_b) - DW'(center_b);
    pass1_r <= in_pass;
    pca_r   <= PW'(da_r) * PW'(cos_val);
    psb_r   <= PW'(db_r) * PW'(sin_val);
    psa_r   <= PW'(da_r) * PW'(sin_val);
    pcb_r   <= PW'(db_r) * PW'(cos_val);
    pass2_r <= pass1_r;
    ra_r    <= ra_nxt;
    rb_r    <= rb_nxt;
    pass3_r <= pass2_r;
  end

  assign out_valid = v3_r;
  assign out_a     = ra_r;
  assign out_b     = rb_r;
  assign out_pass  = pass3_r;

endmodule

[design/vertex_rotate_about_pivot.sv]
// ----------------------------------------------------------------------------
// vertex_rotate_about_pivot
// Rotates Q16.16 vertices about a pivot: X axis, then Y, then Z.
// ----------------------------------------------------------------------------
// The result strobe follows a taken start through three rotation units (three
//   register stages each); one vertex per cycle while busy is low.
// Reset and every config write start a trig sweep through the sine
//   ROM (one lookup per cycle, six lookups); busy is high during it.
// Reset clears angles and pivot to zero; the receiver cannot stall.
`include "assert_macros.svh"

module vertex_rotate_about_pivot #(
  parameter int TRIG_FRAC_BITS     = 14,
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  vrap_pkg::vertex_t                   in_vertex,
  output logic                                out_strobe,
  output vrap_pkg::rotated_t                  out_result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vrap_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vrap_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import vrap_pkg::*;

  localparam int TW      = TRIG_FRAC_BITS + 2;
  localparam int MW      = TRIG_FRAC_BITS + 1;
  localparam int IDX_W   = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int PROD_W  = 14 + IDX_W;
  localparam int LATENCY = 9;
  localparam logic [MW-1:0] TRIG_ONE = MW'(64'd1 << TRIG_FRAC_BITS);
  localparam logic [2:0] LOOKUPS = 3'd6;

  // Quarter-wave sine entry, built at elaboration from a Q30 Taylor series.
  function automatic logic [MW-1:0] sine_entry(input int unsigned idx);
    logic [63:0] theta;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    theta = 64'(idx) * HALF_PI_Q30 / 64'(SINE_TABLE_ENTRIES);
    term  = theta;
    sum   = longint'(theta);
    for (int k = 1; k <= 12; k++) begin
      term = (term * theta) >> 30;
      term = (term * theta) >> 30;
      term = term / TAYLOR_DIV[k];
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = ((64'(sum) << TRIG_FRAC_BITS) + (64'd1 << 29)) >> 30;
    if (v > 64'(TRIG_ONE) || idx == SINE_TABLE_ENTRIES) begin
      v = 64'(TRIG_ONE);
    end
    return MW'(v);
  endfunction

  logic [MW-1:0] sine_rom [SINE_TABLE_ENTRIES+1];

  for (genvar g = 0; g <= SINE_TABLE_ENTRIES; g++) begin : g_sine
    assign sine_rom[g] = sine_entry(g);
  end

  // Configuration registers
  logic [ANGLE_W-1:0] angle_r  [3];
  coord_t             center_r [3];
  logic               cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        angle_r[i]  <= '0;
        center_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_ANGLE_X:  angle_r[0]  <= cfg_data[ANGLE_W-1:0];
        CFG_ANGLE_Y:  angle_r[1]  <= cfg_data[ANGLE_W-1:0];
        CFG_ANGLE_Z:  angle_r[2]  <= cfg_data[ANGLE_W-1:0];
        CFG_CENTER_X: center_r[0] <= coord_t'(cfg_data[COORD_WIDTH-1:0]);
        CFG_CENTER_Y: center_r[1] <= coord_t'(cfg_data[COORD_WIDTH-1:0]);
        CFG_CENTER_Z: center_r[2] <= coord_t'(cfg_data[COORD_WIDTH-1:0]);
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Trig sweep: lookup n covers axis n/2, sine for even n, cosine for odd n.
  // Issue the ROM address one cycle, write the signed value back the next.
  logic                    trig_busy_r;
  logic [2:0]              trig_cnt_r;
  logic                    lk_vld_r;
  logic [2:0]              lk_dst_r;
  logic                    lk_neg_r;
  logic [MW-1:0]           lk_mag_r;
  logic signed [TW-1:0]    sin_r [3];
  logic signed [TW-1:0]    cos_r [3];

  logic [ANGLE_W-1:0]      lk_base;
  logic [ANGLE_W-1:0]      lk_angle;
  logic [PROD_W-1:0]       lk_prod;
  logic [IDX_W-1:0]        lk_k;
  logic [IDX_W-1:0]        lk_idx;
  logic                    lk_issue;
  logic signed [TW-1:0]    lk_val;

  always_comb begin
    unique case (trig_cnt_r[2:1])
      2'd0:    lk_base = angle_r[0];
      2'd1:    lk_base = angle_r[1];
      default: lk_base = angle_r[2];
    endcase
    // cosine is the sine a quarter turn ahead
    lk_angle = lk_base + (trig_cnt_r[0] ? QUARTER_TURN : '0);
    lk_prod  = PROD_W'(lk_angle[13:0]) * PROD_W'(SINE_TABLE_ENTRIES);
    lk_k     = lk_prod[PROD_W-1:14];
    lk_idx   = lk_angle[14] ? IDX_W'(SINE_TABLE_ENTRIES) - lk_k : lk_k;
    lk_issue = trig_busy_r && (trig_cnt_r < LOOKUPS);
    lk_val   = lk_neg_r ? -TW'(lk_mag_r) : TW'(lk_mag_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_busy_r <= 1'b1;
      trig_cnt_r  <= '0;
      lk_vld_r    <= 1'b0;
    end else begin
      lk_vld_r <= lk_issue;
      if (cfg_wr) begin
        // restart the sweep so it picks up the new register
        trig_busy_r <= 1'b1;
        trig_cnt_r  <= '0;
      end else if (trig_busy_r) begin
        if (trig_cnt_r == LOOKUPS) begin
          trig_busy_r <= 1'b0;
        end else begin
          trig_cnt_r <= trig_cnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    lk_mag_r <= sine_rom[lk_idx];
    lk_neg_r <= lk_angle[15];
    lk_dst_r <= trig_cnt_r;
    if (lk_vld_r) begin
      for (int i = 0; i < 3; i++) begin
        if (lk_dst_r[2:1] == 2'(i)) begin
          if (lk_dst_r[0]) begin
            cos_r[i] <= lk_val;
          end else begin
            sin_r[i] <= lk_val;
          end
        end
      end
    end
  end

  assign busy = trig_busy_r;

  // Rotation chain. X axis: (y, z); Y axis: (z, x); Z axis: (x, y).
  logic   in_take;
  logic   vx, vy, vz;
  coord_t x1_y, x1_z, x1_x;
  coord_t y1_z, y1_x, y1_y;
  coord_t z1_x, z1_y, z1_z;

  assign in_take = start && !busy;

  vrap_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_take),
    .in_a     (in_vertex.pos_y),
    .in_b     (in_vertex.pos_z),
    .in_pass  (in_vertex.pos_x),
    .center_a (center_r[1]),
    .center_b (center_r[2]),
    .sin_val  (sin_r[0]),
    .cos_val  (cos_r[0]),
    .out_valid(vx),
    .out_a    (x1_y),
    .out_b    (x1_z),
    .out_pass (x1_x)
  );

  vrap_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vx),
    .in_a     (x1_z),
    .in_b     (x1_x),
    .in_pass  (x1_y),
    .center_a (center_r[2]),
    .center_b (center_r[0]),
    .sin_val  (sin_r[1]),
    .cos_val  (cos_r[1]),
    .out_valid(vy),
    .out_a    (y1_z),
    .out_b    (y1_x),
    .out_pass (y1_y)
  );

  vrap_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vy),
    .in_a     (y1_x),
    .in_b     (y1_y),
    .in_pass  (y1_z),
    .center_a (center_r[0]),
    .center_b (center_r[1]),
    .sin_val  (sin_r[2]),
    .cos_val  (cos_r[2]),
    .out_valid(vz),
    .out_a    (z1_x),
    .out_b    (z1_y),
    .out_pass (z1_z)
  );

  // Last stage registers drive the ports directly: one beat per strobe.
  assign out_strobe           = vz;
  assign out_result.rotated_x = z1_x;
  assign out_result.rotated_y = z1_y;
  assign out_result.rotated_z = z1_z;

  `ASSERT_IMPLIES(a_latency, in_take, ##LATENCY out_strobe)
  `ASSERT_IMPLIES(a_busy_cause, $rose(busy), $past(cfg_wr))
  `ASSERT_IMPLIES(a_trig_range, lk_vld_r, (lk_mag_r <= TRIG_ONE) && (lk_dst_r < LOOKUPS))

endmodule
